[hw/rtl/avg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the arc vertex generator.
package avg_pkg;

	localparam int COORD_W     = 32;          // coordinate width
	localparam int DIFF_W      = COORD_W + 1; // start minus centre
	localparam int COEF_W      = 32;          // rotation coefficient magnitude width
	localparam int COEF_FRAC   = 30;          // Q2.30 fraction bits
	localparam int RS_W        = 31;          // radius factor width
	localparam int VEC_W       = 50;          // rotated vector magnitude width
	localparam int CHUNK_W     = VEC_W / 2;   // multiplier operand slice
	localparam int PP_W        = CHUNK_W + COEF_W;
	localparam int ACC_W       = VEC_W + COEF_W + 1;
	localparam int CFG_IDX_W   = 2;

	localparam int SEGMENTS_DEF      = 40;
	localparam int VEC_FRAC_BITS_DEF = 16;

	localparam logic [COEF_W-1:0] ROT_COS_RST = 32'd1060522291;
	localparam logic [COEF_W-1:0] ROT_SIN_RST = 32'd167970246;
	localparam logic [RS_W-1:0]   RADIUS_RST  = 31'd1073741824;

	typedef enum logic [CFG_IDX_W-1:0] {
		IDX_ROT_COS      = 2'd0,
		IDX_ROT_SIN      = 2'd1,
		IDX_RADIUS_SCALE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FRAC_FULL    = 2'd0,
		FRAC_HALF    = 2'd1,
		FRAC_QUARTER = 2'd2
	} frac_code_t;

	// control into the multiply-accumulate unit
	typedef struct packed {
		logic vld;     // issue a partial product this cycle
		logic clr;     // first partial product of a sum
		logic sub;     // subtract this partial product
		logic hi;      // operand is the upper slice
		logic rot;     // rounding by the coefficient fraction (else by the scale shift)
		logic ext_neg; // sign of an unsigned scale sum
	} mac_ctl_t;

	function automatic logic [COORD_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

[hw/rtl/avg_mac.sv]
`timescale 1ns / 1ps
// Shared sliced multiplier, signed accumulator and round/saturate stage.
module avg_mac
	import avg_pkg::*;
#(
	parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl,
	input  logic [CHUNK_W-1:0] op_a,
	input  logic [COEF_W-1:0]  op_b,
	output logic [VEC_W-1:0]   rnd_mag,
	output logic               rnd_neg
);

	localparam int SH = COEF_FRAC - VEC_FRAC_BITS;
	localparam logic [ACC_W-1:0] HALF_ROT = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic [ACC_W-1:0] HALF_SCL = ACC_W'(1) << (SH - 1);
	localparam logic [ACC_W-1:0] VMIN_MAG = ACC_W'(1) << (VEC_W - 1);
	localparam logic [ACC_W-1:0] VMAX     = VMIN_MAG - ACC_W'(1);

	logic [PP_W-1:0]  pp_s1;
	logic             vld_s1;
	logic             clr_s1;
	logic             sub_s1;
	logic             hi_s1;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] pp_sh;
	logic [ACC_W-1:0] acc_base;
	logic             acc_neg;
	logic [ACC_W-1:0] half;
	logic [ACC_W-1:0] rsum;
	logic [ACC_W-1:0] shifted;
	logic [ACC_W-1:0] limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1  <= op_a * op_b;
		clr_s1 <= ctl.clr;
		sub_s1 <= ctl.sub;
		hi_s1  <= ctl.hi;
		if (vld_s1) begin
			acc_q <= sub_s1 ? (acc_base - pp_sh) : (acc_base + pp_sh);
		end
	end

	assign pp_sh    = hi_s1 ? (ACC_W'(pp_s1) << CHUNK_W) : ACC_W'(pp_s1);
	assign acc_base = clr_s1 ? '0 : acc_q;

	// round half away from zero on the magnitude, then clamp to the vector range
	always_comb begin
		acc_neg = acc_q[ACC_W-1];
		half    = ctl.rot ? HALF_ROT : HALF_SCL;
		rsum    = acc_neg ? (half - acc_q) : (acc_q + half);
		shifted = ctl.rot ? (rsum >> COEF_FRAC) : (rsum >> SH);
		rnd_neg = acc_neg | ctl.ext_neg;
		limit   = rnd_neg ? VMIN_MAG : VMAX;
		rnd_mag = (shifted > limit) ? limit[VEC_W-1:0] : shifted[VEC_W-1:0];
	end

endmodule

[hw/rtl/arc_vertex_generator.sv]
`timescale 1ns / 1ps
// Arc vertex generator: polygon vertices of a full, half or quarter circle.
//
// One input beat (s_axis) carries a centre and a start vertex; tuser picks the
// fraction of the circle and asks for an exact 90-degree end point on quarters.
// The block answers with a run of vertex beats on m_axis, tlast on the final one.
// Run length is SEGMENTS/div beats (div 1, 2 or 4) plus one for the exact end.
// The user must write registers through cfg_we/cfg_index/cfg_data only while it idles;
// the block itself does not enforce this.
//
// The start vertex goes from the emit state into the output register, then the
// radius scaling runs; each rotation is eight 25x32 partial products through one
// shared multiplier, each coordinate followed by a drain and a round/saturate state,
// then the vector-round and sum states round the vector and add the centre. The
// exact end point, if asked for, is made in its own state.
// s_axis_tready is high only in idle; one item is worked on at a time.
// The output register lets the sequencer move on while a vertex waits; a
// stalled receiver holds the next vertex back and the sequencer waits on it.
// Reset restores the register defaults and drops any run in progress.
module arc_vertex_generator
	import avg_pkg::*;
#(
	parameter int SEGMENTS      = SEGMENTS_DEF,
	parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [127:0]         s_axis_tdata,  // center_x, center_y, start_x, start_y
	input  logic [7:0]           s_axis_tuser,  // fraction_code[1:0], add_exact_end, zeros
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // vertex_x, vertex_y
	output logic                 m_axis_tlast,  // last_vertex
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int STEP_W = $clog2(SEGMENTS);
	localparam int RV_W   = VEC_W - VEC_FRAC_BITS;
	localparam int SUM_W  = ((RV_W > COORD_W) ? RV_W : COORD_W) + 2;
	localparam logic [STEP_W-1:0] STEPS_FULL = STEP_W'(SEGMENTS - 1);
	localparam logic [STEP_W-1:0] STEPS_HALF = STEP_W'(SEGMENTS / 2 - 1);
	localparam logic [STEP_W-1:0] STEPS_QTR  = STEP_W'(SEGMENTS / 4 - 1);
	localparam logic [VEC_W-1:0]  VHALF      = VEC_W'(1) << (VEC_FRAC_BITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMIT,
		ST_PREP,
		ST_MUL,
		ST_DRAIN,
		ST_RND,
		ST_VRND,
		ST_VSUM,
		ST_EXACT
	} state_t;

	state_t state_q;

	// configuration, coefficients kept as sign and magnitude
	logic [COEF_W-1:0] cos_mag_q;
	logic              cos_neg_q;
	logic [COEF_W-1:0] sin_mag_q;
	logic              sin_neg_q;
	logic [RS_W-1:0]   rs_q;

	// sequencer
	logic [STEP_W-1:0] steps_q;
	logic              exact_q;
	logic              first_q;
	logic              job_rot_q;  // 0 radius scaling, 1 rotation
	logic              axis_q;     // 0 x, 1 y
	logic [1:0]        k_q;        // partial product index
	logic              olast_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic              m_tlast_q;

	// datapath
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic [DIFF_W-1:0]         dx_mag_q, dy_mag_q;
	logic                      dx_neg_q, dy_neg_q;
	logic [VEC_W-1:0]          vxm_q, vym_q, nxm_q;
	logic                      vxn_q, vyn_q, nxn_q;
	logic [RV_W-1:0]           rvx_q, rvy_q;
	logic [COORD_W-1:0]        ox_q, oy_q;

	// input fields
	logic signed [COORD_W-1:0] in_cx, in_cy, in_sx, in_sy;
	logic [1:0]                in_code;
	logic                      in_exact;
	logic [STEP_W-1:0]         steps_d;
	logic                      exact_d;

	logic              accept;
	logic              out_free;
	mac_ctl_t          mac_ctl;
	logic [VEC_W-1:0]  src_mag;
	logic [COEF_W-1:0] coef;
	logic              term_sub;
	logic [CHUNK_W-1:0] op_a;
	logic [VEC_W-1:0]  rnd_mag;
	logic              rnd_neg;
	logic [1:0]        k_last;

	logic signed [SUM_W-1:0] cx_ext, cy_ext, rvx_ext, rvy_ext, sum_x, sum_y;
	logic signed [63:0]      ex_x, ex_y;

	assign in_cx    = s_axis_tdata[31:0];
	assign in_cy    = s_axis_tdata[63:32];
	assign in_sx    = s_axis_tdata[95:64];
	assign in_sy    = s_axis_tdata[127:96];
	assign in_code  = s_axis_tuser[1:0];
	assign in_exact = s_axis_tuser[2];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

	// rotations per run; code three counts as a full circle
	always_comb begin
		unique case (in_code)
			FRAC_HALF:    steps_d = STEPS_HALF;
			FRAC_QUARTER: steps_d = STEPS_QTR;
			default:      steps_d = STEPS_FULL;
		endcase
		exact_d = (in_code == FRAC_QUARTER) && in_exact;
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_mag_q <= ROT_COS_RST;
			cos_neg_q <= 1'b0;
			sin_mag_q <= ROT_SIN_RST;
			sin_neg_q <= 1'b0;
			rs_q      <= RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				IDX_ROT_COS: begin
					cos_mag_q <= cfg_data[COEF_W-1] ? (~cfg_data + COEF_W'(1)) : cfg_data;
					cos_neg_q <= cfg_data[COEF_W-1];
				end
				IDX_ROT_SIN: begin
					sin_mag_q <= cfg_data[COEF_W-1] ? (~cfg_data + COEF_W'(1)) : cfg_data;
					sin_neg_q <= cfg_data[COEF_W-1];
				end
				IDX_RADIUS_SCALE: begin
					rs_q <= cfg_data[RS_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	// rotation x: cos*x - sin*y, rotation y: sin*x + cos*y, k[1] picks the term
	always_comb begin
		if (!job_rot_q) begin
			src_mag  = axis_q ? VEC_W'(dy_mag_q) : VEC_W'(dx_mag_q);
			coef     = {1'b0, rs_q};
			term_sub = 1'b0;
		end else if (!axis_q) begin
			if (!k_q[1]) begin
				src_mag  = vxm_q;
				coef     = cos_mag_q;
				term_sub = cos_neg_q ^ vxn_q;
			end else begin
				src_mag  = vym_q;
				coef     = sin_mag_q;
				term_sub = !(sin_neg_q ^ vyn_q);
			end
		end else begin
			if (!k_q[1]) begin
				src_mag  = vxm_q;
				coef     = sin_mag_q;
				term_sub = sin_neg_q ^ vxn_q;
			end else begin
				src_mag  = vym_q;
				coef     = cos_mag_q;
				term_sub = cos_neg_q ^ vyn_q;
			end
		end
		op_a            = k_q[0] ? src_mag[VEC_W-1:CHUNK_W] : src_mag[CHUNK_W-1:0];
		mac_ctl.vld     = (state_q == ST_MUL);
		mac_ctl.clr     = (k_q == 2'd0);
		mac_ctl.sub     = term_sub;
		mac_ctl.hi      = k_q[0];
		mac_ctl.rot     = job_rot_q;
		mac_ctl.ext_neg = !job_rot_q && (axis_q ? dy_neg_q : dx_neg_q);
		k_last          = job_rot_q ? 2'd3 : 2'd1;
	end

	avg_mac #(
		.VEC_FRAC_BITS(VEC_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (coef),
		.rnd_mag(rnd_mag),
		.rnd_neg(rnd_neg)
	);

	// centre plus rounded vector, and the exact quarter end point
	always_comb begin
		cx_ext  = SUM_W'(cx_q);
		cy_ext  = SUM_W'(cy_q);
		rvx_ext = $signed({{(SUM_W-RV_W){1'b0}}, rvx_q});
		rvy_ext = $signed({{(SUM_W-RV_W){1'b0}}, rvy_q});
		sum_x   = vxn_q ? (cx_ext - rvx_ext) : (cx_ext + rvx_ext);
		sum_y   = vyn_q ? (cy_ext - rvy_ext) : (cy_ext + rvy_ext);
		ex_x    = 64'(cx_q) - 64'(dy_q);
		ex_y    = 64'(cy_q) + 64'(dx_q);
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			steps_q    <= '0;
			exact_q    <= 1'b0;
			first_q    <= 1'b0;
			job_rot_q  <= 1'b0;
			axis_q     <= 1'b0;
			k_q        <= '0;
			olast_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// the emit state loads the output register itself
			if (m_axis_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						steps_q <= steps_d;
						exact_q <= exact_d;
						olast_q <= (steps_d == '0) && !exact_d;
						first_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {oy_q, ox_q};
						m_tlast_q  <= olast_q;
						first_q    <= 1'b0;
						if (olast_q) begin
							state_q <= ST_IDLE;
						end else if (first_q) begin
							state_q <= ST_PREP;
						end else if (steps_q != '0) begin
							job_rot_q <= 1'b1;
							axis_q    <= 1'b0;
							k_q       <= '0;
							state_q   <= ST_MUL;
						end else begin
							state_q <= ST_EXACT;
						end
					end
				end
				ST_PREP: begin
					job_rot_q <= 1'b0;
					axis_q    <= 1'b0;
					k_q       <= '0;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					if (k_q == k_last) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_MUL;
					end else if (!job_rot_q) begin
						job_rot_q <= 1'b1;
						axis_q    <= 1'b0;
						state_q   <= ST_MUL;
					end else begin
						axis_q  <= 1'b0;
						steps_q <= steps_q - STEP_W'(1);
						state_q <= ST_VRND;
					end
				end
				ST_VRND: begin
					olast_q <= (steps_q == '0) && !exact_q;
					state_q <= ST_VSUM;
				end
				ST_VSUM: begin
					state_q <= ST_EMIT;
				end
				ST_EXACT: begin
					exact_q <= 1'b0;
					olast_q <= 1'b1;
					state_q <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= in_cx;
			cy_q <= in_cy;
			dx_q <= DIFF_W'(in_sx) - DIFF_W'(in_cx);
			dy_q <= DIFF_W'(in_sy) - DIFF_W'(in_cy);
			ox_q <= in_sx;
			oy_q <= in_sy;
		end
		case (state_q)
			ST_PREP: begin
				dx_mag_q <= dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
				dy_mag_q <= dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
				dx_neg_q <= dx_q[DIFF_W-1];
				dy_neg_q <= dy_q[DIFF_W-1];
			end
			ST_RND: begin
				if (!job_rot_q) begin
					if (!axis_q) begin
						vxm_q <= rnd_mag;
						vxn_q <= rnd_neg;
					end else begin
						vym_q <= rnd_mag;
						vyn_q <= rnd_neg;
					end
				end else if (!axis_q) begin
					// new x waits until y has used the old x
					nxm_q <= rnd_mag;
					nxn_q <= rnd_neg;
				end else begin
					vym_q <= rnd_mag;
					vyn_q <= rnd_neg;
					vxm_q <= nxm_q;
					vxn_q <= nxn_q;
				end
			end
			ST_VRND: begin
				rvx_q <= RV_W'((vxm_q + VHALF) >> VEC_FRAC_BITS);
				rvy_q <= RV_W'((vym_q + VHALF) >> VEC_FRAC_BITS);
			end
			ST_VSUM: begin
				ox_q <= sat32({{(64-SUM_W){sum_x[SUM_W-1]}}, sum_x});
				oy_q <= sat32({{(64-SUM_W){sum_y[SUM_W-1]}}, sum_y});
			end
			ST_EXACT: begin
				ox_q <= sat32(ex_x);
				oy_q <= sat32(ex_y);
			end
			default: ;
		endcase
	end

endmodule

[sim/arc_vertex_generator_checker.sv]
`timescale 1ns / 1ps
// Vertex predictor and beat comparator for the arc vertex generator.
module arc_vertex_generator_checker
	import avg_pkg::*;
#(
	parameter int SEGMENTS      = SEGMENTS_DEF,
	parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [127:0]         s_axis_tdata,  // center_x, center_y, start_x, start_y
	input  logic [7:0]           s_axis_tuser,  // fraction_code[1:0], add_exact_end, zeros
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [63:0]          m_axis_tdata,  // vertex_x, vertex_y
	input  logic                 m_axis_tlast,  // last_vertex
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   expected_left,
	output int                   arcs_seen,
	output int                   vertices_seen
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} vertex_t;

	localparam wide_t VEC_LIMIT = 128'sd1 <<< (VEC_W - 1);
	localparam wide_t COORD_MAX = (128'sd1 <<< (COORD_W - 1)) - 1;
	localparam wide_t COORD_MIN = -(128'sd1 <<< (COORD_W - 1));

	logic signed [COEF_W-1:0] cos_q30;
	logic signed [COEF_W-1:0] sin_q30;
	logic [RS_W-1:0]          radius_q30;
	vertex_t                  pending_vertices[$];
	int                       fails;
	int                       arcs;
	int                       vertices;

	// shift right, rounding half away from zero
	function automatic wide_t round_away(input wide_t v, input int sh);
		wide_t a;
		a = (v < 0) ? -v : v;
		a = (a + (128'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -a : a;
	endfunction

	function automatic logic signed [VEC_W-1:0] clamp_vec(input wide_t v);
		if (v > VEC_LIMIT - 1) begin
			return VEC_W'(VEC_LIMIT - 1);
		end else if (v < -VEC_LIMIT) begin
			return VEC_W'(-VEC_LIMIT);
		end
		return VEC_W'(v);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input wide_t v);
		if (v > COORD_MAX) begin
			return COORD_W'(COORD_MAX);
		end else if (v < COORD_MIN) begin
			return COORD_W'(COORD_MIN);
		end
		return COORD_W'(v);
	endfunction

	function automatic logic [COORD_W-1:0] vertex_coord(input logic signed [COORD_W-1:0] c,
			input logic signed [VEC_W-1:0] v);
		wide_t t;
		t = v;
		t = c + round_away(t, VEC_FRAC_BITS);
		return clamp_coord(t);
	endfunction

	// all vertices of one arc, in emission order
	task automatic predict_arc(input logic [127:0] beat, input logic [7:0] flags);
		logic signed [COORD_W-1:0] cx, cy, sx, sy;
		logic signed [DIFF_W-1:0]  dx, dy;
		logic signed [VEC_W-1:0]   vx, vy;
		wide_t                     nx, ny, scale;
		int                        steps;
		logic                      exact_end;
		{sy, sx, cy, cx} = beat;
		dx = sx - cx;
		dy = sy - cy;
		case (frac_code_t'(flags[1:0]))
			FRAC_HALF:    steps = SEGMENTS / 2 - 1;
			FRAC_QUARTER: steps = SEGMENTS / 4 - 1;
			default:      steps = SEGMENTS - 1; // spare code runs a full circle
		endcase
		exact_end = (flags[1:0] == FRAC_QUARTER) && flags[2];
		scale = $signed({1'b0, radius_q30});
		nx = dx * scale;
		ny = dy * scale;
		vx = clamp_vec(round_away(nx, COEF_FRAC - VEC_FRAC_BITS));
		vy = clamp_vec(round_away(ny, COEF_FRAC - VEC_FRAC_BITS));
		pending_vertices.push_back('{x: sx, y: sy, last: (steps == 0 && !exact_end)});
		for (int k = 1; k <= steps; k++) begin
			nx = vx * cos_q30 - vy * sin_q30;
			ny = vx * sin_q30 + vy * cos_q30;
			vx = clamp_vec(round_away(nx, COEF_FRAC));
			vy = clamp_vec(round_away(ny, COEF_FRAC));
			pending_vertices.push_back('{x: vertex_coord(cx, vx), y: vertex_coord(cy, vy),
				last: (k == steps && !exact_end)});
		end
		if (exact_end) begin
			nx = cx - dy;
			ny = cy + dx;
			pending_vertices.push_back('{x: clamp_coord(nx), y: clamp_coord(ny), last: 1'b1});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			cos_q30    = ROT_COS_RST;
			sin_q30    = ROT_SIN_RST;
			radius_q30 = RADIUS_RST;
			pending_vertices.delete();
			fails    = 0;
			arcs     = 0;
			vertices = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					IDX_ROT_COS:      cos_q30 = cfg_data;
					IDX_ROT_SIN:      sin_q30 = cfg_data;
					IDX_RADIUS_SCALE: radius_q30 = cfg_data[RS_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_arc(s_axis_tdata, s_axis_tuser);
				arcs++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				vertices++;
				if (pending_vertices.size() == 0) begin
					$error("vertex beat with no vertex expected");
					fails++;
				end else begin
					want = pending_vertices.pop_front();
					if (m_axis_tdata[31:0] !== want.x) begin
						$error("vertex_x: expected %0d, got %0d", $signed(want.x),
							$signed(m_axis_tdata[31:0]));
						fails++;
					end
					if (m_axis_tdata[63:32] !== want.y) begin
						$error("vertex_y: expected %0d, got %0d", $signed(want.y),
							$signed(m_axis_tdata[63:32]));
						fails++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_vertex: expected %0b, got %0b", want.last, m_axis_tlast);
						fails++;
					end
				end
			end
		end
		fail_count    <= fails;
		expected_left <= pending_vertices.size();
		arcs_seen     <= arcs;
		vertices_seen <= vertices;
	end

endmodule

[sim/arc_vertex_generator_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the arc vertex generator: stimulus, stalls and verdict.
module arc_vertex_generator_tb;
	import avg_pkg::*;

	localparam int STALL_LIMIT      = 2000; // cycles with no beat on either side
	localparam int DRAIN_CYCLES     = 40;   // settle time once nothing is expected
	localparam int RANDOM_ARCS      = 100;
	localparam int ARCS_PER_SETTING = 25;

	// fraction code outside the enum; the block treats it as a full circle
	localparam logic [1:0]  FRAC_SPARE = 2'd3;
	localparam logic [31:0] COORD_LOW  = 32'h8000_0000;
	localparam logic [31:0] COORD_HIGH = 32'h7FFF_FFFF;
	localparam logic [31:0] COEF_PLUS  = 32'h4000_0000; // +1.0 in Q2.30
	localparam logic [31:0] COEF_MINUS = 32'hC000_0000; // -1.0 in Q2.30

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [127:0]         s_axis_tdata;
	logic [7:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [63:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	int   fail_count;
	int   expected_left;
	int   arcs_seen;
	int   vertices_seen;
	int   settings_used;
	logic no_idle = 1'b0; // both sides run flat out while set

	arc_vertex_generator dut (.*);

	arc_vertex_generator_checker vertex_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver drops tready about 30% of cycles unless in the no-idle stretch
	always @(posedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
	end

	// give up when neither side has moved a beat for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAIL arc_vertex_generator");
		$finish;
	end

	// one arc request; tvalid stays high on return so back-to-back beats need no dip
	task automatic send_arc(input logic signed [31:0] cx, cy, sx, sy,
			input logic [1:0] code, input logic exact_end);
		int gap;
		if (!no_idle && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {sy, sx, cy, cx};
		s_axis_tuser  <= {5'd0, exact_end, code};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop tvalid, let every expected vertex come out, then let the block settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// all three registers back to back; only called with the block idle
	task automatic set_rotation(input logic [31:0] rc, rs, input logic [30:0] scale);
		cfg_we    <= 1'b1;
		cfg_index <= IDX_ROT_COS;
		cfg_data  <= rc;
		@(posedge clk);
		cfg_index <= IDX_ROT_SIN;
		cfg_data  <= rs;
		@(posedge clk);
		cfg_index <= IDX_RADIUS_SCALE;
		cfg_data  <= {1'b0, scale};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// nominal segment angle either way round, or any coefficient pair in range
	task automatic random_setting();
		logic [31:0] rc, rs;
		logic [30:0] scale;
		longint      v;
		case ($urandom_range(3))
			0: begin
				rc = ROT_COS_RST;
				rs = ROT_SIN_RST;
			end
			1: begin
				rc = ROT_COS_RST;
				rs = -ROT_SIN_RST;
			end
			default: begin
				v  = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
				rc = v[31:0];
				v  = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
				rs = v[31:0];
			end
		endcase
		if ($urandom_range(1) != 0) begin
			scale = 31'(RADIUS_RST + $urandom_range(32'h10_0000, 0) - 32'h8_0000);
		end else begin
			scale = 31'($urandom_range(32'h7FFF_FFFF, 0));
		end
		set_rotation(rc, rs, scale);
	endtask

	function automatic logic [31:0] offset_within(input int span);
		logic [31:0] m;
		m = $urandom & ((32'd1 << span) - 1);
		return ($urandom_range(1) != 0) ? -m : m;
	endfunction

	function automatic logic [31:0] extreme_coord();
		case ($urandom_range(4))
			0:       return COORD_LOW;
			1:       return COORD_HIGH;
			2:       return 32'd0;
			3:       return 32'hFFFF_FFFF;
			default: return 32'd1;
		endcase
	endfunction

	// mostly modest radii around any centre; some fully random and corner coordinates
	task automatic send_random_arc();
		logic [31:0] cx, cy, sx, sy;
		int          kind, span;
		kind = $urandom_range(99);
		cx   = $urandom;
		cy   = $urandom;
		if (kind < 60) begin
			span = $urandom_range(24, 0);
			sx   = cx + offset_within(span);
			sy   = cy + offset_within(span);
		end else if (kind < 85) begin
			sx = $urandom;
			sy = $urandom;
		end else begin
			cx = extreme_coord();
			cy = extreme_coord();
			sx = extreme_coord();
			sy = extreme_coord();
		end
		send_arc(cx, cy, sx, sy, 2'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= IDX_ROT_COS;
		cfg_data      <= '0;
		settings_used = 1; // reset defaults count as the first setting
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: every fraction code, exact end on and off
		send_arc(0, 0, 0, 0, FRAC_FULL, 1'b0);                    // zero radius
		send_arc(1000, -2000, 51000, -2000, FRAC_FULL, 1'b1);     // exact end ignored
		send_arc(-7000, 3000, -7000, 803000, FRAC_HALF, 1'b1);    // exact end ignored
		send_arc(250, 250, 123456, -98765, FRAC_QUARTER, 1'b1);
		send_arc(250, 250, 123456, -98765, FRAC_QUARTER, 1'b0);
		send_arc(40000, 40000, 90000, 10000, FRAC_SPARE, 1'b1);   // spare code, full circle
		send_arc(-1, -1, 0, 0, FRAC_FULL, 1'b0);                  // offset of one on each axis, rounding
		// widest offsets: vertices and exact end hit the coordinate rails
		send_arc(COORD_LOW, COORD_LOW, COORD_HIGH, COORD_HIGH, FRAC_QUARTER, 1'b1);
		send_arc(COORD_HIGH, COORD_HIGH, COORD_LOW, COORD_LOW, FRAC_QUARTER, 1'b1);
		send_arc(COORD_HIGH, COORD_LOW, COORD_LOW, COORD_HIGH, FRAC_HALF, 1'b0);
		wait_idle();

		// largest radius factor on the largest offsets
		set_rotation(ROT_COS_RST, ROT_SIN_RST, 31'h7FFF_FFFF);
		send_arc(COORD_LOW, COORD_HIGH, COORD_HIGH, COORD_LOW, FRAC_QUARTER, 1'b1);
		send_arc(0, 0, COORD_HIGH, COORD_LOW, FRAC_FULL, 1'b0);
		wait_idle();

		// cos = sin = +1.0 grows the vector by sqrt(2) a step until it saturates
		set_rotation(COEF_PLUS, COEF_PLUS, RADIUS_RST);
		send_arc(0, 0, COORD_HIGH, 0, FRAC_FULL, 1'b0);
		send_arc(COORD_LOW, COORD_LOW, COORD_HIGH, COORD_HIGH, FRAC_HALF, 1'b0);
		wait_idle();

		// zero radius factor: rotated vertices collapse, exact end still uses the offset
		set_rotation(COEF_MINUS, COEF_MINUS, 31'd0);
		send_arc(12345, -678, 99999, 4242, FRAC_QUARTER, 1'b1);
		wait_idle();

		set_rotation(COEF_MINUS, COEF_PLUS, 31'h7FFF_FFFF);
		send_arc(-5000000, 7000000, 3, -3, FRAC_FULL, 1'b0);
		wait_idle();

		// random arcs, new register setting every 25 arcs, one stretch without idling
		for (int i = 0; i < RANDOM_ARCS; i++) begin
			if (i % ARCS_PER_SETTING == 0) begin
				wait_idle();
				random_setting();
			end
			no_idle <= (i >= 40 && i < 65);
			send_random_arc();
		end
		wait_idle();

		$display("Covered %0d arcs over %0d register settings: all fraction codes,",
			arcs_seen, settings_used);
		$display("exact ends, rail and vector saturation; %0d vertices compared under stalls.",
			vertices_seen);
		if (fail_count == 0 && expected_left == 0) begin
			$display("PASS arc_vertex_generator");
		end else begin
			$display("FAIL arc_vertex_generator");
		end
		$finish;
	end

endmodule

[arc_vertex_generator.f]
hw/rtl/avg_pkg.sv
hw/rtl/avg_mac.sv
hw/rtl/arc_vertex_generator.sv
sim/arc_vertex_generator_checker.sv
sim/arc_vertex_generator_tb.sv
